// File: rtl/core/sst_pkg.sv
// Shared constants for the sorted stop table: table geometry, sentinel,
// status and mode codes. No dependencies; used by the top level.
package sst_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int COL_W     = 15;
  localparam int STATUS_W  = 3;
  localparam int OUT_CNT_W = 4;
  localparam int IDX_W     = $clog2(NUM_SLOTS);

  localparam logic [COL_W-1:0] SENTINEL = COL_W'(32767);
  localparam logic [IDX_W-1:0] CNT_MAX  = IDX_W'(NUM_SLOTS - 1);

  localparam logic MODE_SET   = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_EV   = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

endpackage

// File: rtl/core/sst_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/sorted_stop_table.sv
// Sorted stop table: keeps column stops in ascending order in a RAM.
// Uses sst_pkg and sst_ram.
//
// Usage: a request (in_mode, in_column) is taken when in_valid and
// in_ready are both high; in_mode 0 sets a stop, 1 clears it. Every
// request gives exactly one result (out_status, out_stop_count) on the
// out_ valid/ready channel, held until out_ready takes it.
// The real stops sit in RAM slots 0..count-1; the sentinel and zero
// padding behind them are implied by the stop count and never stored.
// One request is handled at a time. The sequencer walks the stops in
// ascending order, each slot in a read state (address) and then an
// evaluate state (compare and write back), shifting entries up or down
// in the same pass. A rejected column or a full table skips the walk
// and goes straight to the final state.
// in_ready is high only while the sequencer is idle.
// Reset empties the table at once (count zero); the RAM needs no clearing.
// A stalled receiver holds the result in the output register; the next
// request may be accepted meanwhile and waits in its final state until
// the output register frees.
module sorted_stop_table
  import sst_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_mode,
  input  logic [COL_W-1:0]    in_column,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [OUT_CNT_W-1:0] out_stop_count
);

  state_t                state_r, state_nxt;
  logic                  mode_r, mode_nxt;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [IDX_W-1:0]      count_r, count_nxt;
  logic                  moving_r, moving_nxt;
  logic [COL_W-1:0]      carry_r, carry_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [OUT_CNT_W-1:0]  out_cnt_r, out_cnt_nxt;

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [COL_W-1:0]      wr_data;
  logic                  rd_en;
  logic [COL_W-1:0]      rd_data;
  logic                  in_acc;

  sst_ram #(
    .WIDTH (COL_W),
    .DEPTH (NUM_SLOTS)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  assign in_ready       = (state_r == S_IDLE);
  assign in_acc         = in_valid && in_ready;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_stop_count = out_cnt_r;

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    col_nxt        = col_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    moving_nxt     = moving_r;
    carry_nxt      = carry_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_cnt_nxt    = out_cnt_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = carry_r;
    rd_en          = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mode_nxt   = in_mode;
          col_nxt    = in_column;
          idx_nxt    = '0;
          moving_nxt = 1'b0;
          if (in_column >= SENTINEL) begin
            status_nxt = ST_INVALID;
            state_nxt  = S_DONE;
          end else if (in_mode == MODE_SET && count_r == CNT_MAX) begin
            status_nxt = ST_FULL;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end

      S_RD: begin
        if (idx_r == count_r) begin
          // end of the real stops: finish the pass
          state_nxt = S_DONE;
          if (mode_r == MODE_SET) begin
            wr_en      = 1'b1;
            wr_data    = moving_r ? carry_r : col_r;
            count_nxt  = count_r + 1'b1;
            status_nxt = ST_ADDED;
          end else if (moving_r) begin
            count_nxt  = count_r - 1'b1;
            status_nxt = ST_REMOVED;
          end else begin
            status_nxt = ST_ABSENT;
          end
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_EV;
        end
      end

      S_EV: begin
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_RD;
        if (mode_r == MODE_SET) begin
          if (moving_r) begin
            // shift up: drop the carried entry here, carry this one on
            wr_en     = 1'b1;
            wr_data   = carry_r;
            carry_nxt = rd_data;
          end else if (rd_data == col_r) begin
            status_nxt = ST_PRESENT;
            state_nxt  = S_DONE;
          end else if (rd_data > col_r) begin
            wr_en      = 1'b1;
            wr_data    = col_r;
            carry_nxt  = rd_data;
            moving_nxt = 1'b1;
          end
        end else begin
          if (moving_r) begin
            // shift down into the previous slot
            wr_en   = 1'b1;
            wr_addr = idx_r - 1'b1;
            wr_data = rd_data;
          end else if (rd_data == col_r) begin
            moving_nxt = 1'b1;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_cnt_nxt    = OUT_CNT_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      moving_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      moving_r    <= moving_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    col_r        <= col_nxt;
    idx_r        <= idx_nxt;
    carry_r      <= carry_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  // table never holds more stops than the slots behind the sentinel allow
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("stop count out of range");

  // no write lands above the end of the stop list
  a_wr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> wr_addr <= count_r)
    else $error("slot write beyond stop list");

  // count moves only at the end of a scan pass
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != count_nxt) |-> (state_r == S_RD && idx_r == count_r))
    else $error("stop count changed outside end of pass");

  // a result is loaded only from the final state
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && !(out_valid_r && !out_ready)) |-> state_r == S_DONE)
    else $error("result loaded outside final state");

endmodule
